>>> hdl/zoom_pan_viewport_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// Zoom/pan viewport tracker assertion macros
// Shared property forms for the tracker checks.
// ----------------------------------------------------------------------------
`ifndef ZOOM_PAN_VIEWPORT_TRACKER_UNIT_ASSERT_SVH
`define ZOOM_PAN_VIEWPORT_TRACKER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZPVT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZPVT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/zpvt_pkg.sv
// ----------------------------------------------------------------------------
// Zoom/pan viewport tracker package
// Formats, operation codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package zpvt_pkg;

   localparam int FRAC_BITS   = 8;
   localparam int ZOOM_FRAC   = 12;
   localparam int MAX_PRESETS = 4;
   localparam int POS_W       = 21;
   localparam int ZOOM_W      = 16;
   localparam int SRC_W       = 14;
   localparam int CUR_W       = 13;
   localparam int QUO_W       = 22;
   localparam int DIVN_SHIFT  = QUO_W - FRAC_BITS - ZOOM_FRAC;
   localparam int CNT_W       = 5;
   localparam int SW          = 24;
   localparam int MAG_W       = 23;
   localparam int PROD_W      = 39;
   localparam int ALPHA_W     = 16;
   localparam int SLOT_W      = 2;

   localparam logic [ZOOM_W-1:0] ZOOM_ONE        = 16'd4096;
   localparam logic [ZOOM_W-1:0] ZOOM_MAX        = 16'd40960;
   localparam logic [ZOOM_W-1:0] ZOOM_RECALL_RST = 16'd8192;
   localparam logic signed [SW-1:0] ZOOM_SNAP    = 24'sd4;
   localparam logic [POS_W-1:0]  POS_MAX         = 21'h1FFFFF;
   localparam logic [SRC_W-1:0]  SRC_MAX         = 14'd8192;
   localparam logic [PROD_W-1:0] ROUND_HALF      = 39'd32768;

   localparam logic [2:0] OP_CURSOR = 3'd0;
   localparam logic [2:0] OP_TOGGLE = 3'd1;
   localparam logic [2:0] OP_CYCLE  = 3'd2;
   localparam logic [2:0] OP_SET    = 3'd3;
   localparam logic [2:0] OP_TICK   = 3'd4;

   localparam logic [2:0] CSR_SRC_W      = 3'd0;
   localparam logic [2:0] CSR_SRC_H      = 3'd1;
   localparam logic [2:0] CSR_ZOOM_ALPHA = 3'd2;
   localparam logic [2:0] CSR_CUR_ALPHA  = 3'd3;
   localparam logic [2:0] CSR_FOL_ALPHA  = 3'd4;
   localparam logic [2:0] CSR_DZ_FRAC    = 3'd5;
   localparam logic [2:0] CSR_PRESETS    = 3'd6;
   localparam logic [2:0] CSR_PRESET_N   = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_APPLY, ST_ZOOM, ST_SMX, ST_SMY, ST_DIVW, ST_DIVH,
      ST_DZX, ST_WANTX, ST_EASEX, ST_DZY, ST_WANTY, ST_EASEY, ST_OUT
   } state_type;

endpackage

>>> hdl/zoom_pan_viewport_tracker_unit.sv
// ----------------------------------------------------------------------------
// Zoom/pan viewport tracker
// Dead-zone camera follow with eased zoom, smoothed cursor and a clamped view.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | content
//  req_    | in        | req_valid/req_stall  | op, pos_x, pos_y, zoom_value
//  rsp_    | out       | rsp_valid/rsp_stall  | viewport, zoom_level, eased x/y
//  csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A new event is taken only once the last one has left the sequencer.
// Every event runs the 22-step restoring divider once per view axis.
// One shared multiplier performs every easing step and both dead-zone scalings.
// Reset is synchronous and covers state, settings and tracking, not the data path.
// A stalled result waits in the output register while the next event runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zoom_pan_viewport_tracker_unit import zpvt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_op,
   input  logic [CUR_W-1:0]    req_pos_x,
   input  logic [CUR_W-1:0]    req_pos_y,
   input  logic [ZOOM_W-1:0]   req_zoom_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [POS_W-1:0]    rsp_view_left,
   output logic [POS_W-1:0]    rsp_view_top,
   output logic [POS_W-1:0]    rsp_view_width,
   output logic [POS_W-1:0]    rsp_view_height,
   output logic [ZOOM_W-1:0]   rsp_zoom_level,
   output logic [POS_W-1:0]    rsp_eased_x,
   output logic [POS_W-1:0]    rsp_eased_y,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_data
);

   state_type state_ff, state_in;

   logic [2:0]          op_ff, op_in;
   logic [CUR_W-1:0]    px_ff, px_in, py_ff, py_in;
   logic [ZOOM_W-1:0]   zv_ff, zv_in;

   logic [SRC_W-1:0]    src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [ALPHA_W-1:0]  zoom_alpha_ff, zoom_alpha_in;
   logic [ALPHA_W-1:0]  cur_alpha_ff, cur_alpha_in;
   logic [ALPHA_W-1:0]  fol_alpha_ff, fol_alpha_in;
   logic [7:0]          dz_frac_ff, dz_frac_in;
   logic [63:0]         presets_ff, presets_in;
   logic [2:0]          preset_n_ff, preset_n_in;

   logic [CUR_W-1:0]    cursor_x_ff, cursor_x_in, cursor_y_ff, cursor_y_in;
   logic [POS_W-1:0]    smooth_x_ff, smooth_x_in, smooth_y_ff, smooth_y_in;
   logic [POS_W-1:0]    center_x_ff, center_x_in, center_y_ff, center_y_in;
   logic [ZOOM_W-1:0]   zoom_now_ff, zoom_now_in;
   logic [ZOOM_W-1:0]   zoom_goal_ff, zoom_goal_in;
   logic [ZOOM_W-1:0]   zoom_recall_ff, zoom_recall_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                ready_ff, ready_in;

   logic [15:0]         div_rem_ff, div_rem_in;
   logic [QUO_W-1:0]    div_num_ff, div_num_in;
   logic [QUO_W-1:0]    div_quo_ff, div_quo_in;
   logic [CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [QUO_W-1:0]    view_w_ff, view_w_in, view_h_ff, view_h_in;
   logic [POS_W-1:0]    dz_ff, dz_in;
   logic signed [SW-1:0] want_ff, want_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    left_ff, left_in, top_ff, top_in;
   logic [POS_W-1:0]    width_ff, width_in, height_ff, height_in;
   logic [ZOOM_W-1:0]   zoom_out_ff, zoom_out_in;
   logic [POS_W-1:0]    ex_ff, ex_in, ey_ff, ey_in;

   function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] s);
      logic [SRC_W-1:0] r;
      r = s;
      if (s == '0) begin
         r = SRC_W'(1);
      end else if (s > SRC_MAX) begin
         r = SRC_MAX;
      end
      return r;
   endfunction

   function automatic logic [POS_W-1:0] view_edge(input logic [POS_W-1:0] c,
                                                  input logic [QUO_W-1:0] v,
                                                  input logic [QUO_W-1:0] sq);
      logic [QUO_W-1:0] half, hi, cx, e;
      half = v >> 1;
      hi   = sq - half;
      cx   = QUO_W'(c);
      if (cx < half) begin
         cx = half;
      end else if (cx > hi) begin
         cx = hi;
      end
      e = cx - half;
      return e[QUO_W-1] ? POS_MAX : e[POS_W-1:0];
   endfunction

   logic [SRC_W-1:0]    srcc_w, srcc_h, div_src;
   logic [QUO_W-1:0]    swq, shq;
   logic [16:0]         div_trial, div_diff;
   logic                div_ge;
   logic                axis_y;
   logic [QUO_W-1:0]    ax_view, ax_sq, ax_half, ax_hi;
   logic [POS_W-1:0]    ax_center, ax_curpos;
   logic signed [SW-1:0] ease_cur, ease_tgt, ease_d, ease_res, zoom_d;
   logic signed [SW-1:0] dz_lo, dz_hi, cur_s, c_s;
   logic [ALPHA_W-1:0]  ease_alpha, mul_b;
   logic                ease_neg, dz_phase;
   logic [MAG_W-1:0]    ease_mag, mul_a, ease_step;
   logic [PROD_W-1:0]   mul_prod, ease_sum;
   logic [POS_W-1:0]    fol_clamped;
   logic [2:0]          preset_lim, slot_mod;
   logic [ZOOM_W-1:0]   preset_raw;

   assign srcc_w  = clamp_src(src_w_ff);
   assign srcc_h  = clamp_src(src_h_ff);
   assign swq     = QUO_W'(srcc_w) << FRAC_BITS;
   assign shq     = QUO_W'(srcc_h) << FRAC_BITS;
   assign div_src = (state_ff == ST_DIVH) ? srcc_h : srcc_w;

   assign div_trial = {div_rem_ff, div_num_ff[QUO_W-1]};
   assign div_diff  = div_trial - {1'b0, zoom_now_ff};
   assign div_ge    = div_trial >= {1'b0, zoom_now_ff};

   assign axis_y    = (state_ff == ST_SMY) || (state_ff == ST_DZY) ||
                      (state_ff == ST_WANTY) || (state_ff == ST_EASEY);
   assign ax_view   = axis_y ? view_h_ff : view_w_ff;
   assign ax_sq     = axis_y ? shq : swq;
   assign ax_half   = ax_view >> 1;
   assign ax_hi     = ax_sq - ax_half;
   assign ax_center = axis_y ? center_y_ff : center_x_ff;
   assign ax_curpos = POS_W'(axis_y ? cursor_y_ff : cursor_x_ff) << FRAC_BITS;
   assign dz_phase  = (state_ff == ST_DZX) || (state_ff == ST_DZY);

   always_comb begin
      ease_cur   = $signed(SW'(zoom_now_ff));
      ease_tgt   = $signed(SW'(zoom_goal_ff));
      ease_alpha = zoom_alpha_ff;
      unique case (state_ff)
         ST_SMX, ST_SMY: begin
            ease_cur   = $signed(SW'(axis_y ? smooth_y_ff : smooth_x_ff));
            ease_tgt   = $signed(SW'(ax_curpos));
            ease_alpha = cur_alpha_ff;
         end
         ST_EASEX, ST_EASEY: begin
            ease_cur   = $signed(SW'(ax_center));
            ease_tgt   = want_ff;
            ease_alpha = fol_alpha_ff;
         end
         default: begin
         end
      endcase
   end

   assign ease_d    = ease_tgt - ease_cur;
   assign ease_neg  = ease_d[SW-1];
   assign ease_mag  = MAG_W'(ease_neg ? -ease_d : ease_d);
   assign mul_a     = dz_phase ? MAG_W'(ax_view) : ease_mag;
   assign mul_b     = dz_phase ? ALPHA_W'(dz_frac_ff) : ease_alpha;
   assign mul_prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign ease_sum  = mul_prod + ROUND_HALF;
   assign ease_step = ease_sum[PROD_W-1:16];
   assign ease_res  = ease_neg ? ease_cur - $signed({1'b0, ease_step})
                               : ease_cur + $signed({1'b0, ease_step});
   assign zoom_d    = ease_res - $signed(SW'(zoom_goal_ff));

   always_comb begin
      if (ease_res < $signed(SW'(ax_half))) begin
         fol_clamped = ax_half[POS_W-1:0];
      end else if (ease_res > $signed(SW'(ax_hi))) begin
         fol_clamped = ax_hi[POS_W-1:0];
      end else begin
         fol_clamped = ease_res[POS_W-1:0];
      end
   end

   assign cur_s = $signed(SW'(ax_curpos));
   assign c_s   = $signed(SW'(ax_center));
   assign dz_lo = c_s - $signed(SW'(dz_ff));
   assign dz_hi = c_s + $signed(SW'(dz_ff));

   assign preset_lim = (preset_n_ff > 3'(MAX_PRESETS)) ? 3'(MAX_PRESETS) : preset_n_ff;

   always_comb begin
      slot_mod = 3'(slot_ff) + 3'd1;
      for (int i = 0; i < MAX_PRESETS; i++) begin
         if (slot_mod >= preset_lim) begin
            slot_mod = slot_mod - preset_lim;
         end
      end
   end

   assign preset_raw = presets_ff[{slot_mod[SLOT_W-1:0], 4'b0000} +: ZOOM_W];

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      zv_in          = zv_ff;
      src_w_in       = src_w_ff;
      src_h_in       = src_h_ff;
      zoom_alpha_in  = zoom_alpha_ff;
      cur_alpha_in   = cur_alpha_ff;
      fol_alpha_in   = fol_alpha_ff;
      dz_frac_in     = dz_frac_ff;
      presets_in     = presets_ff;
      preset_n_in    = preset_n_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      smooth_x_in    = smooth_x_ff;
      smooth_y_in    = smooth_y_ff;
      center_x_in    = center_x_ff;
      center_y_in    = center_y_ff;
      zoom_now_in    = zoom_now_ff;
      zoom_goal_in   = zoom_goal_ff;
      zoom_recall_in = zoom_recall_ff;
      slot_in        = slot_ff;
      ready_in       = ready_ff;
      div_rem_in     = div_rem_ff;
      div_num_in     = div_num_ff;
      div_quo_in     = div_quo_ff;
      div_cnt_in     = div_cnt_ff;
      view_w_in      = view_w_ff;
      view_h_in      = view_h_ff;
      dz_in          = dz_ff;
      want_in        = want_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      left_in        = left_ff;
      top_in         = top_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      zoom_out_in    = zoom_out_ff;
      ex_in          = ex_ff;
      ey_in          = ey_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SRC_W:      src_w_in      = csr_data[SRC_W-1:0];
            CSR_SRC_H:      src_h_in      = csr_data[SRC_W-1:0];
            CSR_ZOOM_ALPHA: zoom_alpha_in = csr_data[ALPHA_W-1:0];
            CSR_CUR_ALPHA:  cur_alpha_in  = csr_data[ALPHA_W-1:0];
            CSR_FOL_ALPHA:  fol_alpha_in  = csr_data[ALPHA_W-1:0];
            CSR_DZ_FRAC:    dz_frac_in    = csr_data[7:0];
            CSR_PRESETS:    presets_in    = csr_data;
            CSR_PRESET_N:   preset_n_in   = csr_data[2:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               zv_in    = req_zoom_value;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = (op_ff == OP_TICK) ? ST_ZOOM : ST_DIVW;
            unique case (op_ff)
               OP_CURSOR: begin
                  cursor_x_in = px_ff;
                  cursor_y_in = py_ff;
                  if (!ready_ff) begin
                     center_x_in = POS_W'(px_ff) << FRAC_BITS;
                     center_y_in = POS_W'(py_ff) << FRAC_BITS;
                     smooth_x_in = POS_W'(px_ff) << FRAC_BITS;
                     smooth_y_in = POS_W'(py_ff) << FRAC_BITS;
                     ready_in    = 1'b1;
                  end
               end
               OP_TOGGLE: begin
                  zoom_goal_in = (zoom_goal_ff > ZOOM_ONE) ? ZOOM_ONE : zoom_recall_ff;
               end
               OP_CYCLE: begin
                  if (preset_lim != 3'd0) begin
                     slot_in = slot_mod[SLOT_W-1:0];
                     if (preset_raw < ZOOM_ONE) begin
                        zoom_recall_in = ZOOM_ONE;
                        zoom_goal_in   = ZOOM_ONE;
                     end else if (preset_raw > ZOOM_MAX) begin
                        zoom_recall_in = ZOOM_MAX;
                        zoom_goal_in   = ZOOM_MAX;
                     end else begin
                        zoom_recall_in = preset_raw;
                        zoom_goal_in   = preset_raw;
                     end
                  end
               end
               OP_SET: begin
                  if (zv_ff > ZOOM_ONE) begin
                     zoom_recall_in = (zv_ff > ZOOM_MAX) ? ZOOM_MAX : zv_ff;
                     zoom_goal_in   = (zv_ff > ZOOM_MAX) ? ZOOM_MAX : zv_ff;
                  end else begin
                     zoom_goal_in = ZOOM_ONE;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ZOOM: begin
            if ((zoom_d <= ZOOM_SNAP) && (zoom_d >= -ZOOM_SNAP)) begin
               zoom_now_in = zoom_goal_ff;
            end else begin
               zoom_now_in = ease_res[ZOOM_W-1:0];
            end
            state_in = ST_SMX;
         end
         ST_SMX: begin
            smooth_x_in = ease_res[POS_W-1:0];
            state_in    = ST_SMY;
         end
         ST_SMY: begin
            smooth_y_in = ease_res[POS_W-1:0];
            state_in    = ST_DIVW;
         end
         ST_DIVW, ST_DIVH: begin
            if (div_cnt_ff == '0) begin
               div_rem_in = 16'(div_src >> DIVN_SHIFT);
               div_num_in = QUO_W'(div_src) << (QUO_W - DIVN_SHIFT);
               div_quo_in = '0;
               div_cnt_in = CNT_W'(1);
            end else begin
               div_rem_in = div_ge ? div_diff[15:0] : div_trial[15:0];
               div_num_in = div_num_ff << 1;
               div_quo_in = {div_quo_ff[QUO_W-2:0], div_ge};
               div_cnt_in = div_cnt_ff + CNT_W'(1);
               if (div_cnt_ff == CNT_W'(QUO_W)) begin
                  div_cnt_in = '0;
                  if (state_ff == ST_DIVW) begin
                     view_w_in = {div_quo_ff[QUO_W-2:0], div_ge};
                     state_in  = ST_DIVH;
                  end else begin
                     view_h_in = {div_quo_ff[QUO_W-2:0], div_ge};
                     state_in  = (op_ff == OP_TICK) ? ST_DZX : ST_OUT;
                  end
               end
            end
         end
         ST_DZX, ST_DZY: begin
            dz_in    = mul_prod[29:9];
            state_in = (state_ff == ST_DZX) ? ST_WANTX : ST_WANTY;
         end
         ST_WANTX, ST_WANTY: begin
            want_in = c_s;
            if (cur_s < dz_lo) begin
               want_in = cur_s + $signed(SW'(dz_ff));
            end
            if (cur_s > dz_hi) begin
               want_in = cur_s - $signed(SW'(dz_ff));
            end
            state_in = (state_ff == ST_WANTX) ? ST_EASEX : ST_EASEY;
         end
         ST_EASEX: begin
            center_x_in = fol_clamped;
            state_in    = ST_DZY;
         end
         ST_EASEY: begin
            center_y_in = fol_clamped;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               left_in      = view_edge(center_x_ff, view_w_ff, swq);
               top_in       = view_edge(center_y_ff, view_h_ff, shq);
               width_in     = view_w_ff[QUO_W-1] ? POS_MAX : view_w_ff[POS_W-1:0];
               height_in    = view_h_ff[QUO_W-1] ? POS_MAX : view_h_ff[POS_W-1:0];
               zoom_out_in  = zoom_now_ff;
               ex_in        = smooth_x_ff;
               ey_in        = smooth_y_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         src_w_ff       <= 14'd1920;
         src_h_ff       <= 14'd1080;
         zoom_alpha_ff  <= 16'd6554;
         cur_alpha_ff   <= 16'd13107;
         fol_alpha_ff   <= 16'd6554;
         dz_frac_ff     <= 8'd77;
         presets_ff     <= '0;
         preset_n_ff    <= '0;
         cursor_x_ff    <= '0;
         cursor_y_ff    <= '0;
         smooth_x_ff    <= '0;
         smooth_y_ff    <= '0;
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         zoom_now_ff    <= ZOOM_ONE;
         zoom_goal_ff   <= ZOOM_ONE;
         zoom_recall_ff <= ZOOM_RECALL_RST;
         slot_ff        <= '0;
         ready_ff       <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         src_w_ff       <= src_w_in;
         src_h_ff       <= src_h_in;
         zoom_alpha_ff  <= zoom_alpha_in;
         cur_alpha_ff   <= cur_alpha_in;
         fol_alpha_ff   <= fol_alpha_in;
         dz_frac_ff     <= dz_frac_in;
         presets_ff     <= presets_in;
         preset_n_ff    <= preset_n_in;
         cursor_x_ff    <= cursor_x_in;
         cursor_y_ff    <= cursor_y_in;
         smooth_x_ff    <= smooth_x_in;
         smooth_y_ff    <= smooth_y_in;
         center_x_ff    <= center_x_in;
         center_y_ff    <= center_y_in;
         zoom_now_ff    <= zoom_now_in;
         zoom_goal_ff   <= zoom_goal_in;
         zoom_recall_ff <= zoom_recall_in;
         slot_ff        <= slot_in;
         ready_ff       <= ready_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      zv_ff       <= zv_in;
      div_rem_ff  <= div_rem_in;
      div_num_ff  <= div_num_in;
      div_quo_ff  <= div_quo_in;
      view_w_ff   <= view_w_in;
      view_h_ff   <= view_h_in;
      dz_ff       <= dz_in;
      want_ff     <= want_in;
      left_ff     <= left_in;
      top_ff      <= top_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      zoom_out_ff <= zoom_out_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
   end

   assign req_stall       = reset || (state_ff != ST_IDLE);
   assign csr_ready       = !reset;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_view_left   = left_ff;
   assign rsp_view_top    = top_ff;
   assign rsp_view_width  = width_ff;
   assign rsp_view_height = height_ff;
   assign rsp_zoom_level  = zoom_out_ff;
   assign rsp_eased_x     = ex_ff;
   assign rsp_eased_y     = ey_ff;

endmodule

>>> hdl/zpvt_checker.sv
// ----------------------------------------------------------------------------
// Zoom/pan viewport tracker checker
// Port-level checks on the tracker, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "zoom_pan_viewport_tracker_unit_assert.svh"

module zpvt_checker import zpvt_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [ZOOM_W-1:0]  rsp_zoom_level,
   input logic [POS_W-1:0]   rsp_eased_x,
   input logic [POS_W-1:0]   rsp_eased_y
);

   `ZPVT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `ZPVT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "second transfer taken while busy")
   `ZPVT_ASSERT_SAME(a_zoom_range, clock, reset, rsp_valid, (rsp_zoom_level >= ZOOM_ONE) && (rsp_zoom_level <= ZOOM_MAX), "zoom level out of range")
   `ZPVT_ASSERT_SAME(a_cursor_range, clock, reset, rsp_valid, (rsp_eased_x <= 21'd2096896) && (rsp_eased_y <= 21'd2096896), "smoothed cursor beyond source")

endmodule

bind zoom_pan_viewport_tracker_unit zpvt_checker u_zpvt_checker (.*);

>>> tb/sv/zoom_pan_viewport_tracker_unit_test.sv
// ----------------------------------------------------------------------------
// Zoom/pan viewport tracker testbench
// A short directed table runs first, then random event phases under several
// register settings. Each result is checked against a local predictor or, for
// some directed rows, a fixed view. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zoom_pan_viewport_tracker_unit_test;
   import zpvt_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_WAIT = 80;

   typedef struct {
      logic [POS_W-1:0]  left;
      logic [POS_W-1:0]  top;
      logic [POS_W-1:0]  width;
      logic [POS_W-1:0]  height;
      logic [ZOOM_W-1:0] zoom;
      logic [POS_W-1:0]  ex;
      logic [POS_W-1:0]  ey;
   } view_type;

   typedef struct {
      logic [2:0]        op;
      logic [CUR_W-1:0]  px;
      logic [CUR_W-1:0]  py;
      logic [ZOOM_W-1:0] zv;
      bit                typed;
      view_type          want;
   } event_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_op = OP_TICK;
   logic [CUR_W-1:0] req_pos_x = '0;
   logic [CUR_W-1:0] req_pos_y = '0;
   logic [ZOOM_W-1:0] req_zoom_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [POS_W-1:0] rsp_view_left, rsp_view_top, rsp_view_width, rsp_view_height;
   logic [ZOOM_W-1:0] rsp_zoom_level;
   logic [POS_W-1:0] rsp_eased_x, rsp_eased_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = CSR_SRC_W;
   logic [63:0] csr_data = '0;

   zoom_pan_viewport_tracker_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state and register copies.
   longint m_src_w, m_src_h, m_zalpha, m_calpha, m_falpha, m_dz;
   logic [63:0] m_presets;
   int m_preset_n;
   longint m_cur_x, m_cur_y, m_sm_x, m_sm_y, m_ctr_x, m_ctr_y;
   longint m_zoom, m_goal, m_recall;
   int m_slot;
   bit m_ctr_ready;

   view_type views_due[$];
   event_row_type rows[$];
   int errors = 0;
   int n_events = 0, n_views = 0, n_ticks = 0, n_cfg = 0;
   bit steady = 1'b0;

   function automatic longint eased(longint cur, longint tgt, longint a);
      longint d, m, s;
      d = tgt - cur;
      m = d < 0 ? -d : d;
      s = (m * a + 32768) >>> 16;
      return d < 0 ? cur - s : cur + s;
   endfunction

   function automatic longint clampl(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint src_fixed(longint s);
      return clampl(s, 1, 8192) << FRAC_BITS;
   endfunction

   function automatic logic [POS_W-1:0] sat(longint v);
      if (v < 0) return '0;
      if (v > 2097151) return POS_MAX;
      return v[POS_W-1:0];
   endfunction

   function automatic longint chase(longint c, longint cur, longint dz, longint a);
      longint w;
      w = c;
      if (cur < c - dz) w = cur + dz;
      if (cur > c + dz) w = cur - dz;
      return eased(c, w, a);
   endfunction

   task automatic tracker_reset();
      m_src_w = 1920; m_src_h = 1080; m_zalpha = 6554; m_calpha = 13107;
      m_falpha = 6554; m_dz = 77; m_presets = '0; m_preset_n = 0;
      m_cur_x = 0; m_cur_y = 0; m_sm_x = 0; m_sm_y = 0; m_ctr_x = 0; m_ctr_y = 0;
      m_zoom = 4096; m_goal = 4096; m_recall = 8192; m_slot = 0; m_ctr_ready = 0;
   endtask

   task automatic tracker_event(input logic [2:0] op, input longint px, input longint py,
                                input longint zv, output view_type v);
      longint sw, sh, vw, vh, cpx, cpy, d, cx, cy;
      int n;
      sw = src_fixed(m_src_w);
      sh = src_fixed(m_src_h);
      case (op)
         OP_CURSOR: begin
            m_cur_x = px;
            m_cur_y = py;
            if (!m_ctr_ready) begin
               m_ctr_x = px << FRAC_BITS;
               m_ctr_y = py << FRAC_BITS;
               m_sm_x = m_ctr_x;
               m_sm_y = m_ctr_y;
               m_ctr_ready = 1;
            end
         end
         OP_TOGGLE: m_goal = m_goal > 4096 ? 4096 : m_recall;
         OP_CYCLE: begin
            n = m_preset_n > MAX_PRESETS ? MAX_PRESETS : m_preset_n;
            if (n > 0) begin
               m_slot = ((m_slot & 3) + 1) % n;
               m_recall = clampl(longint'((m_presets >> (16 * (m_slot & 3))) & 64'hFFFF),
                                 4096, 40960);
               m_goal = m_recall;
            end
         end
         OP_SET: begin
            if (zv > 4096) begin
               m_recall = zv > 40960 ? 40960 : zv;
               m_goal = m_recall;
            end else begin
               m_goal = 4096;
            end
         end
         OP_TICK: begin
            cpx = m_cur_x << FRAC_BITS;
            cpy = m_cur_y << FRAC_BITS;
            m_zoom = eased(m_zoom, m_goal, m_zalpha);
            d = m_zoom - m_goal;
            if (d <= 4 && d >= -4) m_zoom = m_goal;
            m_sm_x = eased(m_sm_x, cpx, m_calpha);
            m_sm_y = eased(m_sm_y, cpy, m_calpha);
            vw = (sw * 4096) / m_zoom;
            vh = (sh * 4096) / m_zoom;
            m_ctr_x = chase(m_ctr_x, cpx, (vw * m_dz) >>> 9, m_falpha);
            m_ctr_y = chase(m_ctr_y, cpy, (vh * m_dz) >>> 9, m_falpha);
            m_ctr_x = clampl(m_ctr_x, vw >>> 1, sw - (vw >>> 1));
            m_ctr_y = clampl(m_ctr_y, vh >>> 1, sh - (vh >>> 1));
         end
         default: ;
      endcase
      vw = (sw * 4096) / m_zoom;
      vh = (sh * 4096) / m_zoom;
      cx = clampl(m_ctr_x, vw >>> 1, sw - (vw >>> 1));
      cy = clampl(m_ctr_y, vh >>> 1, sh - (vh >>> 1));
      v.left = sat(cx - (vw >>> 1));
      v.top = sat(cy - (vh >>> 1));
      v.width = sat(vw);
      v.height = sat(vh);
      v.zoom = m_zoom[ZOOM_W-1:0];
      v.ex = sat(m_sm_x);
      v.ey = sat(m_sm_y);
   endtask

   function automatic int idle_draw();
      return steady ? 0 : $urandom_range(0, 7);
   endfunction

   // The caller lowers csr_valid after its last write.
   task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      n_cfg++;
      case (idx)
         CSR_SRC_W:      m_src_w = data[13:0];
         CSR_SRC_H:      m_src_h = data[13:0];
         CSR_ZOOM_ALPHA: m_zalpha = data[15:0];
         CSR_CUR_ALPHA:  m_calpha = data[15:0];
         CSR_FOL_ALPHA:  m_falpha = data[15:0];
         CSR_DZ_FRAC:    m_dz = data[7:0];
         CSR_PRESETS:    m_presets = data;
         CSR_PRESET_N:   m_preset_n = data[2:0];
         default: ;
      endcase
   endtask

   task automatic settle();
      while (views_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic send_event(input event_row_type r);
      view_type v;
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= r.op;
      req_pos_x <= r.px;
      req_pos_y <= r.py;
      req_zoom_value <= r.zv;
      do @(posedge clock); while (req_stall);
      tracker_event(r.op, r.px, r.py, r.zv, v);
      if (r.typed) v = r.want;
      views_due.push_back(v);
      n_events++;
      if (r.op == OP_TICK) n_ticks++;
   endtask

   task automatic add_row(input logic [2:0] op, input int px, input int py, input int zv);
      event_row_type r;
      r.op = op; r.px = CUR_W'(px); r.py = CUR_W'(py); r.zv = ZOOM_W'(zv); r.typed = 0;
      r.want = '{default: '0};
      rows.push_back(r);
   endtask

   task automatic add_typed(input logic [2:0] op, input int px, input int py, input int zv,
                            input view_type w);
      add_row(op, px, py, zv);
      rows[$].typed = 1;
      rows[$].want = w;
   endtask

   function automatic event_row_type random_event();
      event_row_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.px = CUR_W'($urandom);
      r.py = CUR_W'($urandom);
      r.zv = ZOOM_W'($urandom);
      r.typed = 0;
      r.want = '{default: '0};
      if (pick < 50) r.op = OP_TICK;
      else if (pick < 72) r.op = OP_CURSOR;
      else if (pick < 80) r.op = OP_TOGGLE;
      else if (pick < 88) r.op = OP_CYCLE;
      else if (pick < 97) begin
         r.op = OP_SET;
         case ($urandom_range(0, 3))
            0: r.zv = ZOOM_W'(4095 + $urandom_range(0, 2));
            1: r.zv = ZOOM_W'(40959 + $urandom_range(0, 2));
            2: r.zv = ZOOM_W'($urandom_range(4096, 40960));
            default: ;
         endcase
      end else r.op = 3'($urandom_range(5, 7));
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // Result side.
   initial begin : result_side
      view_type w;
      int n;
      @(negedge reset);
      forever begin
         n = idle_draw();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         n_views++;
         if (views_due.size() == 0) begin
            $error("result transfer with no event outstanding");
            errors++;
         end else begin
            w = views_due.pop_front();
            check_field("view_left", w.left, rsp_view_left);
            check_field("view_top", w.top, rsp_view_top);
            check_field("view_width", w.width, rsp_view_width);
            check_field("view_height", w.height, rsp_view_height);
            check_field("zoom_level", w.zoom, rsp_zoom_level);
            check_field("eased_x", w.ex, rsp_eased_x);
            check_field("eased_y", w.ey, rsp_eased_y);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   int quiet = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= IDLE_LIMIT) begin
            $display("zoom_pan_viewport_tracker_unit_test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      view_type home;
      logic [63:0] pw;
      logic [15:0] pv;
      int ph;
      tracker_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      home = '{left: 0, top: 0, width: 491520, height: 276480, zoom: 4096, ex: 0, ey: 0};
      add_typed(OP_TICK, 0, 0, 0, home);
      add_typed(3'd5, 8191, 8191, 65535, home);
      home.ex = 25600; home.ey = 12800;
      add_typed(OP_CURSOR, 100, 50, 0, home);
      add_typed(OP_SET, 0, 0, 65535, home);
      add_row(OP_TICK, 0, 0, 0);
      add_row(OP_TICK, 0, 0, 0);
      add_row(OP_TOGGLE, 0, 0, 0);
      add_row(OP_TICK, 0, 0, 0);
      add_row(OP_TOGGLE, 0, 0, 0);
      add_row(OP_CYCLE, 0, 0, 0);
      add_row(OP_SET, 0, 0, 0);
      add_row(OP_SET, 0, 0, 4096);
      add_row(OP_SET, 0, 0, 4097);
      add_row(OP_TICK, 0, 0, 0);
      add_row(OP_CURSOR, 8191, 8191, 0);
      add_row(OP_TICK, 0, 0, 0);
      add_row(OP_CURSOR, 0, 0, 0);
      add_row(OP_TICK, 0, 0, 0);
      add_row(3'd6, 0, 0, 0);
      add_row(3'd7, 0, 0, 0);
      add_row(OP_SET, 0, 0, 40960);
      add_row(OP_TICK, 0, 0, 0);
      foreach (rows[i]) send_event(rows[i]);

      for (ph = 0; ph < 8; ph++) begin
         req_valid <= 1'b0;
         settle();
         pw = {$urandom, $urandom};
         if (ph == 0) begin
            reg_write(CSR_SRC_W, 64'd1);
            reg_write(CSR_SRC_H, 64'd0);
            reg_write(CSR_ZOOM_ALPHA, 64'd0);
            reg_write(CSR_CUR_ALPHA, 64'd0);
            reg_write(CSR_FOL_ALPHA, 64'd0);
            reg_write(CSR_DZ_FRAC, 64'd0);
            reg_write(CSR_PRESETS, 64'h0);
            reg_write(CSR_PRESET_N, 64'd1);
         end else if (ph == 1) begin
            reg_write(CSR_SRC_W, 64'h3FFF);
            reg_write(CSR_SRC_H, 64'd8192);
            reg_write(CSR_ZOOM_ALPHA, 64'hFFFF);
            reg_write(CSR_CUR_ALPHA, 64'hFFFF);
            reg_write(CSR_FOL_ALPHA, 64'hFFFF);
            reg_write(CSR_DZ_FRAC, 64'hFF);
            reg_write(CSR_PRESETS, 64'hFFFF_FFFF_FFFF_FFFF);
            reg_write(CSR_PRESET_N, 64'd7);
         end else begin
            for (int k = 0; k < 4; k++) begin
               pv = 16'($urandom_range(3000, 42000));
               if ($urandom_range(0, 3) == 0) pv = 16'($urandom);
               pw[16*k +: 16] = pv;
            end
            reg_write(CSR_SRC_W, 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                                 : $urandom_range(16, 4096)));
            reg_write(CSR_SRC_H, 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                                 : $urandom_range(16, 4096)));
            reg_write(CSR_ZOOM_ALPHA, 64'($urandom_range(0, 65535)));
            reg_write(CSR_CUR_ALPHA, 64'($urandom_range(0, 65535)));
            reg_write(CSR_FOL_ALPHA, 64'($urandom_range(0, 65535)));
            reg_write(CSR_DZ_FRAC, 64'($urandom_range(0, 255)));
            reg_write(CSR_PRESETS, pw);
            reg_write(CSR_PRESET_N, 64'($urandom_range(0, 7)));
         end
         csr_valid <= 1'b0;
         for (int i = 0; i < 200; i++) begin
            if ($urandom_range(0, 49) == 0) steady = ~steady;
            send_event(random_event());
         end
         steady = 1'b0;
      end
      req_valid <= 1'b0;
      settle();

      $display("Sent %0d events (%0d ticks) and checked %0d results over %0d register writes.",
               n_events, n_ticks, n_views, n_cfg);
      if (errors == 0) begin
         $display("zoom_pan_viewport_tracker_unit_test passed");
      end else begin
         $display("zoom_pan_viewport_tracker_unit_test failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/zpvt_pkg.sv
hdl/zoom_pan_viewport_tracker_unit.sv
hdl/zpvt_checker.sv
tb/sv/zoom_pan_viewport_tracker_unit_test.sv
